// ----- hw/rtl/espc_pkg.sv -----
// shared types and constants for the encoder slide position controller
package espc_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_CMD    = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_RIGHT_TOL = 2'd0,
        REG_LEFT_TOL  = 2'd1
    } cfg_reg_t;

    localparam logic [3:0] VALVE_MOVE_RIGHT = 4'b0110;
    localparam logic [3:0] VALVE_MOVE_LEFT  = 4'b1001;
    localparam logic [3:0] VALVE_STOP_RIGHT = 4'b0001;
    localparam logic [3:0] VALVE_STOP_LEFT  = 4'b0110;
    localparam logic [3:0] VALVE_PULSE_END  = 4'b1101;

    localparam logic [15:0] POS_RESET    = 16'd7;
    localparam logic [7:0]  TARGET_RESET = 8'd7;
    localparam logic [7:0]  ANGLE_RESET  = 8'd90;
    localparam logic [7:0]  TOL_RESET    = 8'd15;
    localparam logic [10:0] SERVO_OFFSET = 11'd300;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

endpackage

// ----- hw/rtl/encoder_slide_position_controller.sv -----
// encoder slide position controller: one result transfer per input transfer
// a result is registered from its input transfer and is on m_axis in the next cycle
// throughput: one item per cycle; input is taken while a result waits if it is taken too
// the output register is the only stage, so an m_axis stall stops s_axis
// reset (aresetn low, synchronous): position 7, target 7, angle 90, valves closed,
// tolerances 15, no result pending
module encoder_slide_position_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // enc_a, enc_b, new_target[7:0], new_angle[7:0], zero pad
    input  logic [1:0]  s_axis_tuser,  // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // slide_position[15:0], valve_bits[3:0], is_moving,
                                       // moving_right, servo_compare[10:0], target_now[7:0], pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0]  right_tol_reg, left_tol_reg;
    logic [15:0] pos_reg, pos_next;
    logic        last_a_reg, last_a_next;
    logic [7:0]  target_reg, target_next;
    logic [7:0]  seen_target_reg, seen_target_next;
    logic        reached_reg, reached_next;
    logic        moving_reg, moving_next;
    logic        dir_reg, dir_next;
    logic        move_pend_reg, move_pend_next;
    logic        stop_pend_reg, stop_pend_next;
    logic [3:0]  valve_reg, valve_next;
    logic [7:0]  angle_reg, angle_next;
    logic        m_valid_reg;
    logic [47:0] m_data_reg, m_data_next;

    logic        in_xfer;
    logic        enc_a, enc_b;
    logic [7:0]  in_target, in_angle;
    logic [10:0] servo_cmp;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign enc_a     = s_axis_tdata[0];
    assign enc_b     = s_axis_tdata[1];
    assign in_target = s_axis_tdata[9:2];
    assign in_angle  = s_axis_tdata[17:10];

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign cfg_ready     = 1'b1;

    // item action followed by the controller pass
    always_comb begin
        logic signed [17:0] pos_s, tgt_s;
        pos_next         = pos_reg;
        last_a_next      = last_a_reg;
        target_next      = target_reg;
        seen_target_next = seen_target_reg;
        reached_next     = reached_reg;
        moving_next      = moving_reg;
        dir_next         = dir_reg;
        move_pend_next   = move_pend_reg;
        stop_pend_next   = stop_pend_reg;
        valve_next       = valve_reg;
        angle_next       = angle_reg;

        case (espc_pkg::op_t'(s_axis_tuser))
            espc_pkg::OP_SAMPLE: begin
                if (enc_a != last_a_reg) begin
                    pos_next    = (enc_a != enc_b) ? pos_reg + 16'd1 : pos_reg - 16'd1;
                    last_a_next = enc_a;
                    if (pos_next == {8'd0, target_reg}) begin
                        reached_next = 1'b1;
                    end
                end
            end
            espc_pkg::OP_CMD: begin
                if (!moving_reg) begin
                    target_next = in_target;
                end
                angle_next = in_angle;
            end
            espc_pkg::OP_TICK: begin
                if (move_pend_reg) begin
                    valve_next = valve_next & espc_pkg::VALVE_PULSE_END;
                end
                if (stop_pend_reg) begin
                    valve_next = 4'd0;
                end
                move_pend_next = 1'b0;
                stop_pend_next = 1'b0;
            end
            default: begin
            end
        endcase

        // position and target as wide signed values so the band compare is exact
        pos_s = {{2{pos_next[15]}}, pos_next};
        tgt_s = {10'd0, target_next};

        if (seen_target_next != target_next) begin
            if (tgt_s > pos_s + $signed({10'd0, right_tol_reg})) begin
                valve_next     = valve_next | espc_pkg::VALVE_MOVE_RIGHT;
                moving_next    = 1'b1;
                dir_next       = 1'b1;
                move_pend_next = 1'b1;
            end else if (tgt_s < pos_s - $signed({10'd0, left_tol_reg})) begin
                valve_next  = valve_next | espc_pkg::VALVE_MOVE_LEFT;
                moving_next = 1'b1;
                dir_next    = 1'b0;
            end
            seen_target_next = target_next;
        end

        if (reached_next && moving_next) begin
            if (dir_next) begin
                valve_next     = valve_next | espc_pkg::VALVE_STOP_RIGHT;
                stop_pend_next = 1'b1;
            end else begin
                valve_next = valve_next & espc_pkg::VALVE_STOP_LEFT;
            end
            moving_next      = 1'b0;
            reached_next     = 1'b0;
            seen_target_next = target_next;
        end
    end

    // angle * 5 + 300 as shift and add
    assign servo_cmp = {1'b0, angle_next, 2'b00} + {3'd0, angle_next} + espc_pkg::SERVO_OFFSET;

    assign m_data_next = {7'd0, target_next, servo_cmp, dir_next, moving_next,
                          valve_next, pos_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            right_tol_reg   <= espc_pkg::TOL_RESET;
            left_tol_reg    <= espc_pkg::TOL_RESET;
            pos_reg         <= espc_pkg::POS_RESET;
            last_a_reg      <= 1'b0;
            target_reg      <= espc_pkg::TARGET_RESET;
            seen_target_reg <= espc_pkg::TARGET_RESET;
            reached_reg     <= 1'b0;
            moving_reg      <= 1'b0;
            dir_reg         <= 1'b0;
            move_pend_reg   <= 1'b0;
            stop_pend_reg   <= 1'b0;
            valve_reg       <= 4'd0;
            angle_reg       <= espc_pkg::ANGLE_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (espc_pkg::cfg_reg_t'(cfg_index))
                    espc_pkg::REG_RIGHT_TOL: right_tol_reg <= cfg_data;
                    espc_pkg::REG_LEFT_TOL:  left_tol_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (in_xfer) begin
                pos_reg         <= pos_next;
                last_a_reg      <= last_a_next;
                target_reg      <= target_next;
                seen_target_reg <= seen_target_next;
                reached_reg     <= reached_next;
                moving_reg      <= moving_next;
                dir_reg         <= dir_next;
                move_pend_reg   <= move_pend_next;
                stop_pend_reg   <= stop_pend_next;
                valve_reg       <= valve_next;
                angle_reg       <= angle_next;
                m_valid_reg     <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            m_data_reg <= m_data_next;
        end
    end

    // a move always records the target it was started for
    a_moving_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        moving_reg |-> (seen_target_reg == target_reg))
        else $error("moving with an unseen target");

    // a stalled result is never overwritten by a new input transfer
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_valid_reg && !m_axis_tready))
        else $error("input taken while result stalled");

    // every input transfer leaves a result behind
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> m_axis_tvalid)
        else $error("input transfer without result");

    // after each input transfer the result's position, valve and target fields match the state registers
    a_result_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (m_data_reg[15:0] == pos_reg) && (m_data_reg[19:16] == valve_reg)
            && (m_data_reg[40:33] == target_reg))
        else $error("result differs from state");

endmodule

// ----- tb/tb_encoder_slide_position_controller.sv -----
// self-checking testbench for the encoder slide position controller
module tb_encoder_slide_position_controller;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_MOVE_STEPS = 400;

    typedef struct {
        logic [15:0] slide_position;
        logic [3:0]  valve_bits;
        logic        is_moving;
        logic        moving_right;
        logic [10:0] servo_compare;
        logic [7:0]  target_now;
    } slide_status_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // enc_a, enc_b, new_target[7:0], new_angle[7:0], pad
    logic [1:0]  s_axis_tuser = espc_pkg::OP_NONE;  // op[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [47:0] m_axis_tdata;  // slide_position, valve_bits, is_moving, moving_right,
                                // servo_compare, target_now, pad
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = espc_pkg::REG_RIGHT_TOL;
    logic [7:0]  cfg_data = '0;

    // controller model state
    logic [15:0] cur_pos;
    logic        prev_a;
    logic [7:0]  cur_target;
    logic [7:0]  acked_target;
    logic        at_target;
    logic        driving;
    logic        heading_right;
    logic        move_pulse;
    logic        stop_pulse;
    logic [3:0]  valves;
    logic [7:0]  cur_angle;
    logic [7:0]  right_tol;
    logic [7:0]  left_tol;

    slide_status_t expected_status[$];
    int errors = 0;
    int sent_items = 0;
    int cycle_count = 0;
    int stall_left = 0;
    bit quiet = 1'b0;

    encoder_slide_position_controller dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    always @(posedge aclk) begin
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else if (!quiet && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 7);
        m_axis_tready <= (stall_left == 0);
    end

    function automatic void reset_model();
        cur_pos       = espc_pkg::POS_RESET;
        prev_a        = 1'b0;
        cur_target    = espc_pkg::TARGET_RESET;
        acked_target  = espc_pkg::TARGET_RESET;
        at_target     = 1'b0;
        driving       = 1'b0;
        heading_right = 1'b0;
        move_pulse    = 1'b0;
        stop_pulse    = 1'b0;
        valves        = '0;
        cur_angle     = espc_pkg::ANGLE_RESET;
        right_tol     = espc_pkg::TOL_RESET;
        left_tol      = espc_pkg::TOL_RESET;
    endfunction

    function automatic int signed_pos();
        return int'($signed(cur_pos));
    endfunction

    // applies one accepted item to the model and queues the status it produces
    function automatic void advance_slide(espc_pkg::op_t op, logic a, logic b, logic [7:0] tgt,
                                          logic [7:0] ang);
        slide_status_t st;
        case (op)
            espc_pkg::OP_SAMPLE: begin
                if (a != prev_a) begin
                    cur_pos = (a != b) ? cur_pos + 16'd1 : cur_pos - 16'd1;
                    prev_a = a;
                    if (signed_pos() == int'(cur_target))
                        at_target = 1'b1;
                end
            end
            espc_pkg::OP_CMD: begin
                if (!driving)
                    cur_target = tgt;
                cur_angle = ang;
            end
            espc_pkg::OP_TICK: begin
                if (move_pulse)
                    valves = valves & espc_pkg::VALVE_PULSE_END;
                if (stop_pulse)
                    valves = '0;
                move_pulse = 1'b0;
                stop_pulse = 1'b0;
            end
            default: ;
        endcase

        // bang-bang decision after every item
        if (acked_target != cur_target) begin
            if (int'(cur_target) > signed_pos() + int'(right_tol)) begin
                valves        = valves | espc_pkg::VALVE_MOVE_RIGHT;
                driving       = 1'b1;
                heading_right = 1'b1;
                move_pulse    = 1'b1;
            end else if (int'(cur_target) < signed_pos() - int'(left_tol)) begin
                valves        = valves | espc_pkg::VALVE_MOVE_LEFT;
                driving       = 1'b1;
                heading_right = 1'b0;
            end
            acked_target = cur_target;
        end
        if (at_target && driving) begin
            if (heading_right) begin
                valves     = valves | espc_pkg::VALVE_STOP_RIGHT;
                stop_pulse = 1'b1;
            end else begin
                valves = valves & espc_pkg::VALVE_STOP_LEFT;
            end
            driving      = 1'b0;
            at_target    = 1'b0;
            acked_target = cur_target;
        end

        st.slide_position = cur_pos;
        st.valve_bits     = valves;
        st.is_moving      = driving;
        st.moving_right   = heading_right;
        st.servo_compare  = {3'b000, cur_angle} * 11'd5 + espc_pkg::SERVO_OFFSET;
        st.target_now     = cur_target;
        expected_status.push_back(st);
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        slide_status_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_status.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, m_axis_tdata);
            end else begin
                want = expected_status.pop_front();
                check_field("slide_position", want.slide_position, m_axis_tdata[15:0]);
                check_field("valve_bits", want.valve_bits, m_axis_tdata[19:16]);
                check_field("is_moving", want.is_moving, m_axis_tdata[20]);
                check_field("moving_right", want.moving_right, m_axis_tdata[21]);
                check_field("servo_compare", want.servo_compare, m_axis_tdata[32:22]);
                check_field("target_now", want.target_now, m_axis_tdata[40:33]);
            end
        end
    end

    // leaves tvalid high after the transfer so the next item can follow back to back
    task automatic send_item(espc_pkg::op_t op, logic a, logic b, logic [7:0] tgt,
                             logic [7:0] ang);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'b000000, ang, tgt, b, a};
        do
            @(posedge aclk);
        while (!s_axis_tready);
        advance_slide(op, a, b, tgt, ang);
        sent_items++;
    endtask

    task automatic step_encoder(bit up);
        logic a;
        a = ~prev_a;
        send_item(espc_pkg::OP_SAMPLE, a, up ? prev_a : a, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic send_tick();
        send_item(espc_pkg::OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_command(logic [7:0] tgt, logic [7:0] ang);
        send_item(espc_pkg::OP_CMD, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  tgt, ang);
    endtask

    // waits until every expected result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_status.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_tolerance(espc_pkg::cfg_reg_t idx, logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        if (idx == espc_pkg::REG_RIGHT_TOL)
            right_tol = value;
        else
            left_tol = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // command a target, mostly near the slide, then walk the encoder toward it with some noise
    task automatic run_move(int max_steps);
        int tgt;
        int steps;
        int pick;
        tgt = signed_pos() + int'($urandom_range(0, 80)) - 40;
        if ($urandom_range(0, 3) == 0)
            tgt = $urandom_range(0, 255);
        if (tgt < 0)
            tgt = 0;
        if (tgt > 255)
            tgt = 255;
        send_command(tgt[7:0], 8'($urandom_range(0, 255)));
        steps = 0;
        while (driving && steps < MAX_MOVE_STEPS && steps < max_steps) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                send_tick();
            else if (pick == 1)
                send_command(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            else if (pick == 2)
                step_encoder(!heading_right);
            else if (pick == 3)
                send_item(espc_pkg::OP_SAMPLE, prev_a, 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            else
                step_encoder(heading_right);
            steps++;
        end
        if (!driving) begin
            repeat ($urandom_range(0, 3)) step_encoder(1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 1))
            send_tick();
    endtask

    task automatic run_noise(int count);
        repeat (count) begin
            send_item(espc_pkg::op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_phase(logic [7:0] rtol, logic [7:0] ltol, int budget);
        int stop_at;
        int pick;
        drain();
        write_tolerance(espc_pkg::REG_RIGHT_TOL, rtol);
        write_tolerance(espc_pkg::REG_LEFT_TOL, ltol);
        stop_at = sent_items + budget;
        while (sent_items < stop_at) begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                run_move(stop_at - sent_items);
            else if (pick < 19)
                run_noise($urandom_range(1, 6));
            else
                drain();
        end
    endtask

    task automatic test_directed();
        // no change on line a, then one count up and back down onto the target while idle
        send_item(espc_pkg::OP_SAMPLE, 1'b0, 1'b1, 8'd0, 8'd0);
        step_encoder(1'b1);
        step_encoder(1'b0);
        send_item(espc_pkg::OP_NONE, 1'b1, 1'b1, 8'hff, 8'hff);
        // the pending reached flag stops the right move at once
        send_command(8'd255, 8'd255);
        send_tick();
        send_command(8'd0, 8'd0);
        drain();
        write_tolerance(espc_pkg::REG_RIGHT_TOL, 8'd0);
        write_tolerance(espc_pkg::REG_LEFT_TOL, 8'd0);
        send_command(8'd1, 8'd45);
        // target is ignored while the slide moves, angle is not
        send_command(8'd200, 8'd128);
        repeat (6) step_encoder(1'b0);
        send_tick();
        send_command(8'd4, 8'd180);
        send_tick();
        repeat (3) step_encoder(1'b1);
        send_tick();
    endtask

    task automatic test_tight_band();
        run_phase(8'd0, 8'd0, 80);
    endtask

    task automatic test_wide_band();
        run_phase(8'd255, 8'd255, 30);
    endtask

    task automatic test_lopsided_band();
        run_phase(8'd0, 8'd255, 60);
        run_phase(8'd255, 8'd0, 60);
    endtask

    task automatic test_random_band();
        run_phase(8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)), 60);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 40);
    endtask

    task automatic test_steady_stream();
        quiet = 1'b1;
        run_phase(8'($urandom_range(0, 20)), 8'($urandom_range(0, 20)), 100);
    endtask

    initial begin
        reset_model();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_tight_band();
        test_wide_band();
        test_lopsided_band();
        test_random_band();
        test_steady_stream();

        drain();
        repeat (5) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
